// File: hdl/pee_pkg.sv
// Shared types and constants of the postfix expression evaluator.
`default_nettype none
package pee_pkg;
    localparam int unsigned STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_FINISH
    } t_op;

    // One command from the tokenizer to the executor.
    typedef struct packed {
        t_op         op;
        logic [31:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_READ,
        EX_CALC,
        EX_DIV,
        EX_WRITE,
        EX_RESULT
    } t_ex_state;

    function automatic logic [7:0] digit_val(input logic [7:0] c);
        return c - CH_ZERO;
    endfunction
endpackage
`default_nettype wire

// File: hdl/pee_front.sv
// Tokenizer: turns characters into push, operator and finish commands.
`default_nettype none
module pee_front
    import pee_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_end_of_expr,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output t_cmd             o_cmd
);
    // Up to three commands per character; emit them one per cycle while i_cmd_ready is high.
    logic        r_busy, n_busy;
    logic [2:0]  r_pend, n_pend;
    t_cmd        r_c0, r_c1, r_c2, n_c0, n_c1, n_c2;
    logic        r_in_num, n_in_num, r_neg, n_neg, r_stop, n_stop;
    logic [31:0] r_acc, n_acc;

    logic is_dig, is_del, is_opr;
    t_cmd        q [0:2];
    logic [1:0]  qn;
    logic [31:0] num_v;

    assign o_ready     = !r_busy;
    assign o_cmd_valid = r_busy;
    assign o_cmd       = r_c0;

    always_comb begin
        is_dig = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        is_del = (i_char_code == CH_SPACE) || (i_char_code == CH_COMMA) ||
                 (i_char_code == 8'd0);
        is_opr = (i_char_code == CH_PLUS) || (i_char_code == CH_MINUS) ||
                 (i_char_code == CH_STAR) || (i_char_code == CH_SLASH);
        n_in_num = r_in_num; n_neg = r_neg; n_stop = r_stop; n_acc = r_acc;
        q[0] = '{op: OP_PUSH, data: 32'd0};
        q[1] = q[0];
        q[2] = q[0];
        qn = 2'd0;
        num_v = 32'd0;
        if (r_in_num) begin
            if (is_del) begin
                q[qn] = '{op: OP_PUSH, data: r_neg ? (32'd0 - r_acc) : r_acc};
                qn = qn + 2'd1;
                n_in_num = 1'b0; n_neg = 1'b0; n_stop = 1'b0; n_acc = 32'd0;
            end else if (is_dig && !r_stop) begin
                n_acc = r_acc * 32'd10 + {24'd0, digit_val(i_char_code)};
            end else begin
                n_stop = 1'b1;
            end
        end else if (r_neg && is_dig) begin
            n_in_num = 1'b1; n_stop = 1'b0;
            n_acc = {24'd0, digit_val(i_char_code)};
        end else begin
            if (r_neg) begin
                n_neg = 1'b0;
                q[qn] = '{op: OP_SUB, data: 32'd0};
                qn = qn + 2'd1;
            end
            if (!is_del) begin
                if (i_char_code == CH_MINUS) begin
                    n_neg = 1'b1;
                end else if (is_opr) begin
                    q[qn] = '{op: (i_char_code == CH_PLUS) ? OP_ADD :
                              (i_char_code == CH_STAR) ? OP_MUL : OP_DIV,
                              data: 32'd0};
                    qn = qn + 2'd1;
                end else begin
                    n_in_num = 1'b1; n_neg = 1'b0;
                    n_stop = !is_dig;
                    n_acc = is_dig ? {24'd0, digit_val(i_char_code)} : 32'd0;
                end
            end
        end
        if (i_end_of_expr) begin
            if (n_in_num) begin
                num_v = n_neg ? (32'd0 - n_acc) : n_acc;
                q[qn] = '{op: OP_PUSH, data: num_v};
                qn = qn + 2'd1;
            end else if (n_neg) begin
                q[qn] = '{op: OP_SUB, data: 32'd0};
                qn = qn + 2'd1;
            end
            q[qn] = '{op: OP_FINISH, data: 32'd0};
            qn = qn + 2'd1;
            n_in_num = 1'b0; n_neg = 1'b0; n_stop = 1'b0; n_acc = 32'd0;
        end
    end

    always_comb begin
        n_busy = r_busy; n_pend = r_pend;
        n_c0 = r_c0; n_c1 = r_c1; n_c2 = r_c2;
        if (r_busy) begin
            if (i_cmd_ready) begin
                n_c0 = r_c1; n_c1 = r_c2;
                n_pend = {1'b0, r_pend[2:1]};
                n_busy = r_pend[1];
            end
        end else if (i_valid) begin
            n_c0 = q[0]; n_c1 = q[1]; n_c2 = q[2];
            n_pend = (qn == 2'd0) ? 3'b000 : (qn == 2'd1) ? 3'b001 :
                     (qn == 2'd2) ? 3'b011 : 3'b111;
            n_busy = qn != 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_pend <= 3'b000;
            r_in_num <= 1'b0; r_neg <= 1'b0; r_stop <= 1'b0; r_acc <= 32'd0;
        end else begin
            r_busy <= n_busy; r_pend <= n_pend;
            if (!r_busy && i_valid) begin
                r_in_num <= n_in_num; r_neg <= n_neg;
                r_stop <= n_stop; r_acc <= n_acc;
            end
        end
        r_c0 <= n_c0; r_c1 <= n_c1; r_c2 <= n_c2;
    end
endmodule
`default_nettype wire

// File: hdl/pee_queue.sv
// Small command queue between the tokenizer and the executor.
`default_nettype none
module pee_queue
    import pee_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);
    t_cmd       r_mem [0:3];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 2'd0; r_rp <= 2'd0; r_cnt <= 3'd0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, wr} - {2'd0, rd};
        end
        if (wr) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// File: hdl/pee_back.sv
// Executor: operand stack, ALU with iterative divider, result register.
`default_nettype none
module pee_back
    import pee_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_cmd         i_cmd,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic signed [31:0] o_value,
    output logic [2:0]        o_status
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [31:0] r_mem [0:STACK_DEPTH-1];
    t_ex_state   r_st, n_st;
    logic [CW-1:0] r_cnt;
    logic [2:0]  r_err;
    t_op         r_op;
    logic [31:0] r_rd, r_a, r_b, r_res;
    logic [31:0] r_q, r_rem, r_div;
    logic [5:0]  r_it;
    logic        r_qneg;
    logic        r_ov;
    logic [32:0] sub;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] cnt_m1, cnt_m2;

    assign cnt_m1 = r_cnt - CW'(1);
    assign cnt_m2 = r_cnt - CW'(2);
    assign o_ready = (r_st == EX_IDLE) && !o_valid;
    assign sub = {r_rem[30:0], r_q[31]} - {1'b0, r_div};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            EX_IDLE: if (i_valid && o_ready) begin
                priority if (i_cmd.op == OP_PUSH) n_st = EX_WRITE;
                else if (i_cmd.op == OP_FINISH)
                    n_st = (r_cnt == '0) ? EX_RESULT : EX_READ;
                else if (r_cnt < CW'(2)) n_st = EX_IDLE;
                else n_st = EX_READ;
            end
            EX_READ:   n_st = (r_op == OP_FINISH) ? EX_IDLE : EX_CALC;
            EX_CALC:   n_st = (r_op == OP_DIV && r_b != 32'd0) ? EX_DIV : EX_WRITE;
            EX_DIV:    if (r_it == 6'd32) n_st = EX_WRITE;
            EX_WRITE:  n_st = EX_IDLE;
            EX_RESULT: n_st = EX_IDLE;
            default:   n_st = EX_IDLE;
        endcase
    end

    // Read address: top for finish and operand b, below top while fetching operand a.
    always_comb begin
        rd_addr = AW'(cnt_m1);
        if (r_st == EX_IDLE && i_cmd.op != OP_FINISH) rd_addr = AW'(cnt_m1);
        if (r_st == EX_READ && r_op != OP_FINISH) rd_addr = AW'(cnt_m2);
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (r_st == EX_WRITE && !r_ov) r_mem[AW'(r_cnt)] <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= EX_IDLE; r_cnt <= '0; r_err <= ST_OK; o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_st)
                EX_IDLE: if (i_valid && o_ready) begin
                    r_op <= i_cmd.op;
                    r_res <= i_cmd.data;
                    r_ov <= r_cnt >= CW'(STACK_DEPTH);
                    if (i_cmd.op == OP_PUSH && r_cnt >= CW'(STACK_DEPTH) && r_err == ST_OK)
                        r_err <= ST_OVER;
                    if (i_cmd.op != OP_PUSH && i_cmd.op != OP_FINISH &&
                        r_cnt < CW'(2) && r_err == ST_OK)
                        r_err <= ST_UNDER;
                end
                EX_READ: if (r_op != OP_FINISH) r_b <= r_rd;
                else begin
                    o_valid <= 1'b1; o_value <= r_rd; o_status <= r_err;
                    r_cnt <= '0; r_err <= ST_OK;
                end
                EX_CALC: begin
                    r_a <= r_rd;
                    r_cnt <= cnt_m2;
                    r_ov <= 1'b0;
                    r_qneg <= r_rd[31] ^ r_b[31];
                    r_q <= r_rd[31] ? 32'd0 - r_rd : r_rd;
                    r_div <= r_b[31] ? 32'd0 - r_b : r_b;
                    r_rem <= 32'd0;
                    r_it <= 6'd0;
                    unique case (r_op)
                        OP_ADD: r_res <= r_rd + r_b;
                        OP_SUB: r_res <= r_rd - r_b;
                        OP_MUL: r_res <= r_rd * r_b;
                        default: begin
                            r_res <= 32'd0;
                            if (r_b == 32'd0 && r_err == ST_OK) r_err <= ST_DIVZ;
                        end
                    endcase
                end
                EX_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (r_it == 6'd32) begin
                        r_res <= r_qneg ? 32'd0 - r_q : r_q;
                    end else begin
                        r_it <= r_it + 6'd1;
                        if (!sub[32]) begin
                            r_rem <= sub[31:0];
                            r_q <= {r_q[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[30:0], r_q[31]};
                            r_q <= {r_q[30:0], 1'b0};
                        end
                    end
                end
                EX_WRITE: if (!r_ov) r_cnt <= r_cnt + CW'(1);
                EX_RESULT: begin
                    o_valid <= 1'b1; o_value <= 32'd0;
                    o_status <= (r_err != ST_OK) ? r_err : ST_EMPTY;
                    r_err <= ST_OK;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/postfix_expression_evaluator_top.sv
// Top level of the postfix expression evaluator.
// Input channel: one ASCII character per request (i_char_code) with
// i_end_of_expr marking the last one. Output channel: one result request
// (o_value, o_status) per expression, given after the last character.
// A tokenizer front end turns characters into push, operator and finish
// commands; a four-entry command queue decouples it from the executor,
// which owns the operand stack memory and a one-bit-per-cycle divider.
// The front end takes no new character while it still emits the commands of
// the last one; the executor takes one command at a time, its 32-step
// divider setting the worst case.
// Reset clears the stack count, token state and error status; stack
// contents are not cleared. While a result waits for i_ready, the executor
// holds and the queue and front end fill, then o_ready drops.
`default_nettype none
module postfix_expression_evaluator_top
    import pee_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_char_code,
    input  wire logic         i_end_of_expr,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic signed [31:0] o_value,
    output logic [2:0]        o_status
);
    t_cmd f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    pee_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_char_code, .i_end_of_expr,
        .o_cmd_valid(f_valid), .i_cmd_ready(f_ready), .o_cmd(f_cmd)
    );

    pee_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_cmd(f_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid, .i_ready, .o_value, .o_status
    );
endmodule
`default_nettype wire
